/* rtl/core/mdt_pkg.sv */
// Shared types, codes and constants of the multi-slot deadline timer.
package mdt_pkg;

  localparam int unsigned ORD_SLOTS_DEF = 4;      // default ordinary slot count
  localparam int unsigned DL_W          = 64;     // deadline / time width
  localparam int unsigned TPS_W         = 32;     // ticks_per_second width
  localparam int unsigned MS_W          = 32;     // delay_ms width
  localparam int unsigned SLOT_W        = 3;      // slot number width
  localparam int unsigned MS_PER_SEC    = 1000;
  localparam int unsigned REM_W         = $clog2(MS_PER_SEC);
  localparam logic [TPS_W-1:0] TPS_RESET = 32'd32768;

  typedef enum logic [1:0] {
    FUNC_CHECK = 2'd0,
    FUNC_SET   = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_GET   = 2'd3
  } func_e;

  typedef enum logic {
    KIND_EVENT = 1'b0,
    KIND_DONE  = 1'b1
  } kind_e;

  typedef struct packed {
    logic [1:0]        func;
    logic [SLOT_W-1:0] slot;
    logic [MS_W-1:0]   delay_ms;
    logic              only_earlier;
    logic [DL_W-1:0]   now;
  } in_item_t;

  typedef struct packed {
    logic              kind;
    logic [SLOT_W-1:0] fired_slot;
    logic [DL_W-1:0]   deadline_value;
    logic [DL_W-1:0]   compare_value;
    logic              bad_slot;
    logic              last;
  } out_item_t;

endpackage

/* rtl/core/mdt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module mdt_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/mdt_tick.sv */
// Deadline computation: now + delay_ms * ticks_per_second / 1000, divide in 16-bit digits.
module mdt_tick
  import mdt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [MS_W-1:0]  delay_ms_i,
  input  logic [TPS_W-1:0] tps_i,
  input  logic [DL_W-1:0]  now_i,
  output logic             done_o,
  output logic [DL_W-1:0]  tick_o
);

  // Long division by 1000, one 16-bit digit per cycle. Each step divides
  // {remainder, digit}, always below 1000 * 2^16, by a reciprocal multiply;
  // the rounded-up reciprocal is exact over that whole range.
  localparam int unsigned DigW    = 16;
  localparam int unsigned Digits  = DL_W / DigW;
  localparam int unsigned CntW    = $clog2(Digits);
  localparam int unsigned XW      = REM_W + DigW;
  localparam int unsigned RecipSh = XW + REM_W;
  localparam int unsigned RecipW  = RecipSh - REM_W + 1;
  localparam logic [RecipW-1:0] Recip =
    RecipW'(((64'd1 << RecipSh) + MS_PER_SEC - 1) / MS_PER_SEC);

  logic            busy_q, add_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [DL_W-1:0] quo_q;       // dividend digits shift out, quotient digits in
  logic [REM_W-1:0] rem_q;
  logic [DL_W-1:0] tick_q;

  logic [DL_W-1:0]      prod;
  logic [XW-1:0]        xdig;
  logic [XW+RecipW-1:0] xprod;
  logic [DigW-1:0]      qdig;
  logic [XW-1:0]        qmul;
  logic [REM_W-1:0]     rem_nx;

  // 32x32 product, registered into the dividend
  assign prod   = DL_W'(delay_ms_i) * DL_W'(tps_i);
  assign xdig   = {rem_q, quo_q[DL_W-1 -: DigW]};
  assign xprod  = (XW+RecipW)'(xdig) * (XW+RecipW)'(Recip);
  assign qdig   = xprod[RecipSh +: DigW];
  assign qmul   = XW'(qdig) * XW'(MS_PER_SEC);
  assign rem_nx = REM_W'(xdig - qmul);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      add_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(Digits - 1)) begin
          busy_q <= 1'b0;
          add_q  <= 1'b1;
        end
      end else if (add_q) begin
        add_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= prod;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[DL_W-DigW-1:0], qdig};
      rem_q <= rem_nx;
    end
    if (add_q) begin
      tick_q <= now_i + quo_q;
    end
  end

  assign done_o = done_q;
  assign tick_o = tick_q;

endmodule

/* rtl/core/multi_slot_deadline_timer_top.sv */
// Top level of the multi-slot deadline timer: sequencer, slot scan and result register.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-----------------------------
//  in      | input     | in_valid_i / in_ready_o  | in_item_i  (func, slot, ...)
//  out     | output    | out_valid_o / out_ready_i| out_item_o (kind, slot, ...)
//  cfg     | input     | cfg_we_i, no wait        | cfg_wdata_i (ticks_per_second)
//
// Steps: check, clear and get run accept, first read, a scan of every slot entry,
//   one emit step per expiry event and then the done item. Set first runs the
//   multiply, the divide by 1000 in four 16-bit digit steps and the add of now.
//   An out-of-range slot skips the scan, except on a check, which scans as usual.
//   The scan runs over the deadline RAM (one read port, one entry a cycle).
// One item at a time: in_ready_o is high while the sequencer is idle.
// Reset clears per-entry valid bits, so every slot reads as idle; no clearing pass.
// A stalled out channel holds the sequencer in its emit step only.
module multi_slot_deadline_timer_top
  import mdt_pkg::*;
#(
  parameter int unsigned OrdinarySlots = ORD_SLOTS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_item_t         in_item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_item_t        out_item_o,
  input  logic             cfg_we_i,
  input  logic [TPS_W-1:0] cfg_wdata_i
);

  localparam int unsigned SlotCount = OrdinarySlots + 1;
  localparam int unsigned IdxW      = $clog2(SlotCount);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SlotCount - 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_TICK = 5'b00010,   // waiting for the deadline computation
    ST_RD0  = 5'b00100,   // first RAM read in flight
    ST_SCAN = 5'b01000,   // one entry per cycle: expire / substitute / min
    ST_EMIT = 5'b10000    // events from the expiry mask, then the done item
  } state_e;

  state_e              state_q, state_d;
  in_item_t            item_q, item_d;
  logic                slot_ok_q, slot_ok_d;
  logic [IdxW-1:0]     entry_q, entry_d;
  logic                bad_q, bad_d;
  logic [IdxW-1:0]     p_q, p_d;           // entry whose read data is present
  logic [DL_W-1:0]     best_q, best_d;     // running earliest armed deadline
  logic [SlotCount-1:0] mask_q, mask_d;    // entries expired by this check
  logic [DL_W-1:0]     dval_q, dval_d;
  logic [DL_W-1:0]     compare_q, compare_d;
  logic [TPS_W-1:0]    tps_q;
  logic [SlotCount-1:0] valid_q;           // entry written since reset
  logic                start_q, start_d;
  logic                out_valid_q, out_valid_d;
  out_item_t           out_item_q, out_item_d;

  // RAM and scan signals
  logic [IdxW-1:0] rd_addr;
  logic [DL_W-1:0] rd_data;
  logic            ram_we;
  logic [DL_W-1:0] d_cur, nv;
  logic            is_tgt, d_nz, expired, take, upd, upd_d, upd_t;
  logic [DL_W-1:0] best_nx;
  logic            tick_done;
  logic [DL_W-1:0] tick;
  logic [IdxW-1:0] first_idx;
  logic            out_free;

  mdt_ram #(
    .Width (DL_W),
    .Depth (SlotCount)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (p_q),
    .wdata_i (nv),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  mdt_tick u_tick (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_q),
    .delay_ms_i (item_q.delay_ms),
    .tps_i      (tps_q),
    .now_i      (item_q.now),
    .done_o     (tick_done),
    .tick_o     (tick)
  );

  // Read the next entry while the current one is processed; each entry is
  // written only in the cycle after its own read, so reads never see a stale value.
  assign rd_addr = (state_q == ST_SCAN) ? p_q + IdxW'(1) : '0;

  // Per-entry decision during the scan
  always_comb begin
    d_cur   = valid_q[p_q] ? rd_data : '0;
    d_nz    = |d_cur;
    is_tgt  = slot_ok_q && (p_q == entry_q);
    upd_d   = d_nz && ((best_q == '0) || (d_cur < best_q));
    upd_t   = (|tick) && ((best_q == '0) || (tick < best_q));
    expired = 1'b0;
    take    = 1'b0;
    ram_we  = 1'b0;
    nv      = d_cur;
    upd     = upd_d;
    unique case (func_e'(item_q.func))
      FUNC_CHECK: begin
        expired = d_nz && (d_cur <= item_q.now);
        if (expired) begin
          nv  = '0;
          upd = 1'b0;
        end
        ram_we = expired && (state_q == ST_SCAN);
      end
      FUNC_SET: begin
        if (is_tgt) begin
          take   = !item_q.only_earlier || !d_nz || (tick < d_cur);
          nv     = take ? tick : d_cur;
          upd    = take ? upd_t : upd_d;
          ram_we = (state_q == ST_SCAN);
        end
      end
      FUNC_CLEAR: begin
        if (is_tgt) begin
          nv     = '0;
          upd    = 1'b0;
          ram_we = (state_q == ST_SCAN);
        end
      end
      FUNC_GET: begin
        // read only
      end
      default: begin
      end
    endcase
    best_nx = upd ? nv : best_q;
  end

  // Lowest expired entry: ordinary slots first, the special slot (last entry) after
  always_comb begin
    first_idx = '0;
    for (int i = SlotCount - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        first_idx = IdxW'(i);
      end
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    slot_ok_d   = slot_ok_q;
    entry_d     = entry_q;
    bad_d       = bad_q;
    p_d         = p_q;
    best_d      = best_q;
    mask_d      = mask_q;
    dval_d      = dval_q;
    compare_d   = compare_q;
    start_d     = 1'b0;
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          item_d    = in_item_i;
          slot_ok_d = in_item_i.slot <= SLOT_W'(OrdinarySlots);
          entry_d   = (in_item_i.slot == '0) ? IdxW'(OrdinarySlots)
                                             : IdxW'(in_item_i.slot - SLOT_W'(1));
          bad_d     = 1'b0;
          dval_d    = '0;
          mask_d    = '0;
          if (in_item_i.func == FUNC_CHECK) begin
            state_d = ST_RD0;
          end else if (in_item_i.slot > SLOT_W'(OrdinarySlots)) begin
            bad_d   = 1'b1;
            state_d = ST_EMIT;
          end else if (in_item_i.func == FUNC_SET) begin
            start_d = 1'b1;
            state_d = ST_TICK;
          end else begin
            state_d = ST_RD0;
          end
        end
      end
      ST_TICK: begin
        if (tick_done) begin
          state_d = ST_RD0;
        end
      end
      ST_RD0: begin
        best_d  = '0;
        p_d     = '0;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        best_d = best_nx;
        if (expired) begin
          mask_d[p_q] = 1'b1;
        end
        if (is_tgt && (item_q.func == FUNC_GET)) begin
          dval_d = d_cur;
        end
        if (p_q == LastIdx) begin
          compare_d = best_nx;
          state_d   = ST_EMIT;
        end else begin
          p_d = p_q + IdxW'(1);
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d              = 1'b1;
          out_item_d.compare_value = compare_q;
          if (|mask_q) begin
            out_item_d.kind           = KIND_EVENT;
            out_item_d.fired_slot     = (first_idx == LastIdx) ? '0
                                      : SLOT_W'(first_idx) + SLOT_W'(1);
            out_item_d.deadline_value = '0;
            out_item_d.bad_slot       = 1'b0;
            out_item_d.last           = 1'b0;
            mask_d[first_idx]         = 1'b0;
          end else begin
            out_item_d.kind           = KIND_DONE;
            out_item_d.fired_slot     = '0;
            out_item_d.deadline_value = dval_q;
            out_item_d.bad_slot       = bad_q;
            out_item_d.last           = 1'b1;
            state_d                   = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      compare_q   <= '0;
      tps_q       <= TPS_RESET;
      valid_q     <= '0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
      mask_q      <= '0;
      p_q         <= '0;
    end else begin
      state_q     <= state_d;
      compare_q   <= compare_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
      mask_q      <= mask_d;
      p_q         <= p_d;
      if (cfg_we_i) begin
        tps_q <= cfg_wdata_i;
      end
      if (ram_we) begin
        valid_q[p_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    slot_ok_q  <= slot_ok_d;
    entry_q    <= entry_d;
    bad_q      <= bad_d;
    best_q     <= best_d;
    dval_q     <= dval_d;
    out_item_q <= out_item_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef ASSERT_OFF
  // the final item of an operation is always its done item
  a_last_is_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.last |-> out_item_o.kind == KIND_DONE)
    else $error("last item is not a done item");

  // expiry events carry no slot error and no deadline
  a_event_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.kind == KIND_EVENT)
      |-> !out_item_o.bad_slot && (out_item_o.deadline_value == '0))
    else $error("malformed expiry event");

  // only a check can leave entries pending for events
  a_mask_check_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) && (item_q.func != FUNC_CHECK) |-> mask_q == '0)
    else $error("expiry mask set outside a check");

  // the deadline unit finishes only while the sequencer waits for it
  a_tick_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_done |-> state_q == ST_TICK)
    else $error("deadline result arrived outside its wait step");
`endif

endmodule

/* tb/tb.sv */
// Self-checking testbench for the multi-slot deadline timer top level.
`timescale 1ns / 1ps

module tb;
  import mdt_pkg::*;

  localparam int unsigned ORD         = ORD_SLOTS_DEF;
  localparam int unsigned ENTRIES     = ORD + 1;
  localparam int unsigned STALL_LIMIT = 4000;  // cycles with no handshake at all
  localparam int unsigned SETTLE      = 80;    // covers the set path (multiply + divide)
  localparam logic [DL_W-1:0] ALL_ONES = '1;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  in_item_t         in_item_i   = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  out_item_t        out_item_o;
  logic             cfg_we_i    = 1'b0;
  logic [TPS_W-1:0] cfg_wdata_i = '0;

  // Predicted timer state: deadline per entry, compare register, tick rate.
  // Ordinary slot s lives at entry s-1, the special slot 0 at entry ORD.
  logic [DL_W-1:0]  mdl_deadline [ENTRIES];
  logic [DL_W-1:0]  mdl_compare;
  logic [TPS_W-1:0] mdl_tps;
  logic [DL_W-1:0]  clock_now;  // running machine time for well-formed items

  in_item_t  pending_items[$];
  out_item_t expected_results[$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int items_accepted = 0;
  int results_seen = 0;
  int events_seen = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  multi_slot_deadline_timer_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Smallest armed deadline, zero when every entry is idle.
  function automatic logic [DL_W-1:0] earliest_deadline();
    logic [DL_W-1:0] best;
    best = '0;
    for (int k = 0; k < ENTRIES; k++) begin
      if (mdl_deadline[k] != '0 && (best == '0 || mdl_deadline[k] < best)) best = mdl_deadline[k];
    end
    return best;
  endfunction

  // Entry index of a slot number, -1 when the number is out of range.
  function automatic int slot_to_entry(logic [SLOT_W-1:0] s);
    if (s == '0) return ORD;
    if (s <= ORD) return int'(s) - 1;
    return -1;
  endfunction

  // Applies one operation to the predicted state and queues its results:
  // expiry events first (slots 1..ORD, then slot 0), then the done item.
  function automatic void predict_timer_op(in_item_t it);
    out_item_t       res;
    out_item_t       batch[$];
    logic [DL_W-1:0] tick;
    logic [DL_W-1:0] dval;
    logic            bad;
    int              e;
    e    = slot_to_entry(it.slot);
    dval = '0;
    bad  = 1'b0;
    if (func_e'(it.func) == FUNC_CHECK) begin
      for (int k = 0; k < ENTRIES; k++) begin
        if (mdl_deadline[k] != '0 && mdl_deadline[k] <= it.now) begin
          mdl_deadline[k] = '0;
          res = '0;
          res.kind = KIND_EVENT;
          res.fired_slot = (k == ORD) ? '0 : SLOT_W'(k + 1);
          batch.push_back(res);
        end
      end
      mdl_compare = earliest_deadline();
    end else if (e < 0) begin
      bad = 1'b1;
    end else begin
      case (func_e'(it.func))
        FUNC_SET: begin
          // both factors fit in 32 bits, so the product fits in 64; sum wraps
          tick = it.now + (DL_W'(it.delay_ms) * DL_W'(mdl_tps)) / MS_PER_SEC;
          if (!it.only_earlier || mdl_deadline[e] == '0 || tick < mdl_deadline[e]) begin
            mdl_deadline[e] = tick;
            mdl_compare = earliest_deadline();
          end
        end
        FUNC_CLEAR: begin
          if (mdl_deadline[e] != '0) begin
            mdl_deadline[e] = '0;
            mdl_compare = earliest_deadline();
          end
        end
        default: dval = mdl_deadline[e];
      endcase
    end
    res = '0;
    res.kind = KIND_DONE;
    res.deadline_value = dval;
    res.bad_slot = bad;
    res.last = 1'b1;
    batch.push_back(res);
    // every item of one operation carries the final compare value
    foreach (batch[i]) begin
      batch[i].compare_value = mdl_compare;
      expected_results.push_back(batch[i]);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic add_item(func_e f, int unsigned s, logic [MS_W-1:0] ms, logic oe,
                          logic [DL_W-1:0] t);
    in_item_t it;
    it = '0;
    it.func = f;
    it.slot = SLOT_W'(s);
    it.delay_ms = ms;
    it.only_earlier = oe;
    it.now = t;
    pending_items.push_back(it);
  endtask

  // Mostly well-formed traffic on a rising time base so that sets get
  // expired by later checks; about one item in five is raw noise.
  function automatic in_item_t random_item();
    in_item_t it;
    int       pick;
    it = '0;
    if ($urandom_range(99) < 20) begin
      it.func = 2'($urandom);
      it.slot = SLOT_W'($urandom);
      it.delay_ms = $urandom;
      it.only_earlier = 1'($urandom);
      it.now = {$urandom, $urandom};
      return it;
    end
    clock_now += DL_W'($urandom_range(30)) * mdl_tps / MS_PER_SEC + DL_W'($urandom_range(20));
    pick = $urandom_range(99);
    it.func = (pick < 40) ? FUNC_SET : (pick < 70) ? FUNC_CHECK :
              (pick < 80) ? FUNC_CLEAR : FUNC_GET;
    it.slot = ($urandom_range(9) == 0) ? SLOT_W'($urandom_range(7, ORD + 1))
                                       : SLOT_W'($urandom_range(ORD));
    it.delay_ms = ($urandom_range(19) == 0) ? $urandom : MS_W'($urandom_range(60));
    it.only_earlier = 1'($urandom);
    it.now = clock_now;
    return it;
  endfunction

  // Sender holds off until every queued item is out and every result is in.
  task automatic drain();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || in_valid_i || expected_results.size() != 0);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_tps(logic [TPS_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mdl_tps = v;
  endtask

  // One random phase: new tick rate, idling mix, then n items.
  task automatic run_phase(logic [TPS_W-1:0] tps, int n, int tx_pct, int rx_pct);
    drain();
    write_tps(tps);
    @(negedge clk_i);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (n) pending_items.push_back(random_item());
  endtask

  task automatic report_mismatch(string what, out_item_t want, out_item_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%t %s", $realtime, what);
      $display("  exp kind %0d slot %0d dl %h cmp %h bad %0d last %0d", want.kind,
               want.fired_slot, want.deadline_value, want.compare_value, want.bad_slot, want.last);
      $display("  got kind %0d slot %0d dl %h cmp %h bad %0d last %0d", got.kind,
               got.fired_slot, got.deadline_value, got.compare_value, got.bad_slot, got.last);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents queued items, holds valid and payload until accepted.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      predict_timer_op(in_item_i);
      items_accepted++;
    end
    if (rst_ni && (!in_valid_i || in_ready_o)) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_item_i <= pending_items.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each accepted result against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (out_valid_o && out_ready_i) begin
      results_seen++;
      if (out_item_o.kind == KIND_EVENT) events_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected", '0, out_item_o);
      end else begin
        want = expected_results.pop_front();
        if (out_item_o.kind !== want.kind ||
            out_item_o.fired_slot !== want.fired_slot ||
            out_item_o.deadline_value !== want.deadline_value ||
            out_item_o.compare_value !== want.compare_value ||
            out_item_o.bad_slot !== want.bad_slot ||
            out_item_o.last !== want.last) begin
          report_mismatch("result mismatch", want, out_item_o);
        end
      end
    end
    out_ready_i <= rst_ni && ($urandom_range(99) >= rx_idle_pct);
  end

  // Watchdog: any handshake restarts the count.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence of the run
  // ---------------------------------------------------------------------------
  initial begin : run
    foreach (mdl_deadline[k]) mdl_deadline[k] = '0;
    mdl_compare = '0;
    mdl_tps = TPS_RESET;
    clock_now = 64'd1000;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part at the reset tick rate (32768 ticks per second).
    add_item(FUNC_GET,   0, 0, 1'b0, '0);                 // idle slot reads zero
    add_item(FUNC_CHECK, 0, 0, 1'b0, '0);                 // nothing armed
    add_item(FUNC_SET,   1, 10, 1'b0, 64'd1000);          // deadline 1327
    add_item(FUNC_SET,   0, 0, 1'b0, 64'd2000);           // zero delay: deadline = now
    add_item(FUNC_SET,   4, '1, 1'b0, '0);                // largest delay
    add_item(FUNC_SET,   5, 3, 1'b0, 64'd10);             // out-of-range slots
    add_item(FUNC_CLEAR, 7, 0, 1'b0, '0);
    add_item(FUNC_GET,   6, 0, 1'b1, '0);
    add_item(FUNC_SET,   1, 100, 1'b1, 64'd1000);         // later: not taken
    add_item(FUNC_SET,   1, 1, 1'b1, 64'd1000);           // earlier: taken, 1032
    add_item(FUNC_GET,   1, 0, 1'b0, '0);
    add_item(FUNC_CLEAR, 2, 0, 1'b0, '0);                 // clear of an idle slot
    add_item(FUNC_SET,   2, 1000, 1'b0, ALL_ONES - 64'd32767);  // wraps to exactly zero
    add_item(FUNC_SET,   3, 5, 1'b1, 64'd1010);           // only-earlier on idle slot
    add_item(FUNC_CHECK, 0, 0, 1'b0, 64'd1500);           // slots 1 and 3 expire
    add_item(FUNC_CHECK, 0, 0, 1'b0, 64'd2000);           // special slot expires
    add_item(FUNC_SET,   1, 1, 1'b0, 64'd3000);
    add_item(FUNC_SET,   2, 2, 1'b0, 64'd3000);
    add_item(FUNC_SET,   3, 3, 1'b0, 64'd3000);
    add_item(FUNC_SET,   0, 4, 1'b0, 64'd3000);
    add_item(FUNC_CHECK, 0, 0, 1'b0, ALL_ONES);           // all five slots fire
    add_item(FUNC_SET,   4, 2, 1'b0, 64'd5000);
    add_item(FUNC_CLEAR, 4, 0, 1'b0, '0);
    add_item(FUNC_GET,   4, 0, 1'b0, '0);

    // Random phases over tick rates including both ends of the range and zero.
    run_phase(32'd1000, 25, 69, 0);
    run_phase('1,       25, 0, 69);
    run_phase(32'd1,    15, 37, 37);
    run_phase('0,       15, 0, 0);
    run_phase($urandom, 16, 37, 37);
    drain();

    $display("Ran %0d items (24 directed) over six tick-rate settings incl. 0, 1 and max",
             items_accepted);
    $display("Checked %0d results, %0d expiry events; %0d mismatches",
             results_seen, events_seen, mismatches);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/mdt_pkg.sv
rtl/core/mdt_ram.sv
rtl/core/mdt_tick.sv
rtl/core/multi_slot_deadline_timer_top.sv
tb/tb.sv
